### design/rrfq_pkg.sv
// ----------------------------------------------------------------------------
// rrfq_pkg
// Shared types and constants for the four-queue round-robin merge.
// ----------------------------------------------------------------------------
package rrfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int IDENT_BITS_DEF  = 40;

  localparam int NUM_QUEUES      = 4;
  localparam int QUEUE_SEL_BITS  = 2;

  // Entries in the command queue between the front and the back.
  localparam int CMD_QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [QUEUE_SEL_BITS-1:0] {
    DIR_WEST  = 2'd0,
    DIR_NORTH = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_EAST  = 2'd3
  } dir_t;

  typedef struct packed {
    kind_t kind;
    dir_t  dir;
  } cmd_ctrl_t;

endpackage

### design/round_robin_four_queue_merge.sv
// ----------------------------------------------------------------------------
// round_robin_four_queue_merge
// Four identifier queues (west, north, south, east) merged in round-robin
// order on pop requests.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser is the word kind (push or pop), s_tdata holds
// the direction and the identifier. A push appends the identifier to the
// queue its direction names; a push to a full queue is dropped. A pop takes
// the head of the first non-empty queue, scanning cyclically from the queue
// after the last one served; once every queue is empty the scan restarts
// at west.
// Output channel m_*: one result word per input word, in input order.
// m_tuser carries the status, m_tdata the popped identifier and its queue
// (both zero on push results and on pops that find every queue empty).
// From input accept, the word sits in the front command queue until the
// back end executes it and loads the result register. Its single memory
// port serves one push write or one pop read each cycle. Throughput is one
// word per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the result register holds and the two-entry
// command queue fills, then s_tready falls. Reset empties all queues and
// points the scan at west; the store contents are not cleared.
// ----------------------------------------------------------------------------
module round_robin_four_queue_merge import rrfq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int IDENT_BITS  = IDENT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // direction [1:0], ident [IDENT_BITS+1:2], zero padding above
  input  logic [((IDENT_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
  // kind [0]
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // out_ident [IDENT_BITS-1:0], out_direction [IDENT_BITS+1:IDENT_BITS],
  // zero padding above
  output logic [((IDENT_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
  // status [1:0]
  output logic [1:0]                            m_tuser
);

  localparam int DATA_BITS = ((IDENT_BITS + 2 + 7) / 8) * 8;

  logic                  cmd_valid;
  logic                  cmd_ready;
  cmd_ctrl_t             cmd_ctrl;
  logic [IDENT_BITS-1:0] cmd_ident;
  status_t               out_status;
  logic [IDENT_BITS-1:0] out_ident;
  logic [1:0]            out_dir;
  logic [DATA_BITS-1:0]  out_word;

  rrfq_front #(
    .IDENT_BITS (IDENT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_dir    (s_tdata[1:0]),
    .in_ident  (s_tdata[IDENT_BITS+1:2]),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_ident (cmd_ident)
  );

  rrfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDENT_BITS  (IDENT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_ctrl   (cmd_ctrl),
    .cmd_ident  (cmd_ident),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_ident  (out_ident),
    .out_dir    (out_dir)
  );

  always_comb begin
    out_word = '0;
    out_word[IDENT_BITS-1:0]          = out_ident;
    out_word[IDENT_BITS+1:IDENT_BITS] = out_dir;
  end

  assign m_tdata = out_word;
  assign m_tuser = out_status;

endmodule

### design/rrfq_front.sv
// ----------------------------------------------------------------------------
// rrfq_front
// Accepts input words, classifies them into push or pop commands and holds
// them in a short command queue for the back end.
// ----------------------------------------------------------------------------
module rrfq_front import rrfq_pkg::*; #(
  parameter int IDENT_BITS = IDENT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [1:0]            in_dir,
  input  logic [IDENT_BITS-1:0] in_ident,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_ctrl_t             cmd_ctrl,
  output logic [IDENT_BITS-1:0] cmd_ident
);

  localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(CMD_QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(CMD_QUEUE_DEPTH);

  cmd_ctrl_t             slot_ctrl  [CMD_QUEUE_DEPTH];
  logic [IDENT_BITS-1:0] slot_ident [CMD_QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [FW-1:0]         fill;
  logic                  push_cmd;
  logic                  pop_cmd;
  cmd_ctrl_t             in_ctrl;

  // A pop names no queue, so its direction is cleared here.
  always_comb begin
    in_ctrl.kind = kind_t'(in_kind);
    in_ctrl.dir  = (kind_t'(in_kind) == KIND_POP) ? DIR_WEST : dir_t'(in_dir);
  end

  assign in_ready  = (fill != FILL_MAX);
  assign cmd_valid = (fill != '0);
  assign push_cmd  = in_valid && in_ready;
  assign pop_cmd   = cmd_valid && cmd_ready;
  assign cmd_ctrl  = slot_ctrl[rd_ptr];
  assign cmd_ident = slot_ident[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_cmd) begin
      slot_ctrl[wr_ptr]  <= in_ctrl;
      slot_ident[wr_ptr] <= in_ident;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_cmd) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_cmd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push_cmd && !pop_cmd) begin
        fill <= fill + 1'b1;
      end else if (pop_cmd && !push_cmd) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### design/rrfq_back.sv
// ----------------------------------------------------------------------------
// rrfq_back
// Executes push and pop commands against the four queues held in one
// shared memory, keeps the round-robin pointer and drives the result
// register.
// ----------------------------------------------------------------------------
module rrfq_back import rrfq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int IDENT_BITS  = IDENT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_ctrl_t             cmd_ctrl,
  input  logic [IDENT_BITS-1:0] cmd_ident,
  output logic                  out_valid,
  input  logic                  out_ready,
  output status_t               out_status,
  output logic [IDENT_BITS-1:0] out_ident,
  output logic [1:0]            out_dir
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = QUEUE_SEL_BITS + IW;
  localparam int MEM_WORDS = NUM_QUEUES << IW;
  localparam logic [IW-1:0] SLOT_LAST  = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

  logic [IDENT_BITS-1:0] mem [MEM_WORDS];
  logic [IDENT_BITS-1:0] rd_data;
  logic [IW-1:0]         head  [NUM_QUEUES];
  logic [IW-1:0]         tail  [NUM_QUEUES];
  logic [CW-1:0]         count [NUM_QUEUES];
  logic [1:0]            next_queue;

  logic                  take;
  logic                  is_push;
  logic                  is_pop;
  logic                  push_full;
  logic                  pop_found;
  logic [1:0]            pop_sel;
  logic                  busy_after;
  logic                  do_write;
  logic                  do_read;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign is_push   = (cmd_ctrl.kind == KIND_PUSH);
  assign is_pop    = (cmd_ctrl.kind == KIND_POP);
  assign push_full = (count[cmd_ctrl.dir] == COUNT_FULL);

  // Cyclic scan from next_queue; the first queue holding an entry wins.
  always_comb begin
    logic [1:0] q;
    pop_found = 1'b0;
    pop_sel   = '0;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      q = next_queue + 2'(k);
      if (!pop_found && (count[q] != '0)) begin
        pop_found = 1'b1;
        pop_sel   = q;
      end
    end
  end

  // Whether any entry is left once the selected head is taken.
  always_comb begin
    busy_after = 1'b0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (2'(i) == pop_sel) begin
        busy_after = busy_after || (count[i] > CW'(1));
      end else begin
        busy_after = busy_after || (count[i] != '0);
      end
    end
  end

  assign do_write = take && is_push && !push_full;
  assign do_read  = take && is_pop && pop_found;
  assign wr_addr  = {cmd_ctrl.dir, tail[cmd_ctrl.dir]};
  assign rd_addr  = {pop_sel, head[pop_sel]};

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= cmd_ident;
    end
    if (do_read) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
      next_queue <= DIR_WEST;
      out_valid  <= 1'b0;
      out_status <= ST_PUSHED;
      out_dir    <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        out_dir <= (is_pop && pop_found) ? pop_sel : '0;
        if (is_push) begin
          if (push_full) begin
            out_status <= ST_DROPPED;
          end else begin
            out_status           <= ST_PUSHED;
            tail[cmd_ctrl.dir]   <= (tail[cmd_ctrl.dir] == SLOT_LAST) ?
                                    '0 : tail[cmd_ctrl.dir] + 1'b1;
            count[cmd_ctrl.dir]  <= count[cmd_ctrl.dir] + 1'b1;
          end
        end else if (pop_found) begin
          out_status     <= ST_POPPED;
          head[pop_sel]  <= (head[pop_sel] == SLOT_LAST) ? '0 : head[pop_sel] + 1'b1;
          count[pop_sel] <= count[pop_sel] - 1'b1;
          // A drained store restarts the scan at west.
          next_queue     <= busy_after ? pop_sel + 2'd1 : DIR_WEST;
        end else begin
          out_status <= ST_EMPTY;
        end
      end
    end
  end

  // rd_data changes only on a pop, which needs a free result register.
  assign out_ident = (out_status == ST_POPPED) ? rd_data : '0;

endmodule

### design/rrfq_checker.sv
// ----------------------------------------------------------------------------
// rrfq_checker
// Port-level checks for the four-queue round-robin merge, bound to the top.
// ----------------------------------------------------------------------------
module rrfq_checker import rrfq_pkg::*; #(
  parameter int IDENT_BITS = IDENT_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [((IDENT_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
  input logic                                  s_tuser,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((IDENT_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
  input logic [1:0]                            m_tuser
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Reset leaves no result pending and the command queue open.
  assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result or back-pressure present after reset");

  // Only a successful pop carries an identifier and a direction.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_POPPED) |-> m_tdata == '0)
    else $error("non-pop result carries data");

  // With no output stall the command queue never fills.
  assert property (@(posedge clk) disable iff (rst)
    m_tready && $past(m_tready) && !$past(rst) |-> s_tready)
    else $error("input back-pressured while the output drains");

endmodule

bind round_robin_four_queue_merge rrfq_checker #(
  .IDENT_BITS (IDENT_BITS)
) u_rrfq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-queue round-robin merge. Push and pop
// words go in on the s_* stream. A predictor in the bench keeps its own
// copy of the four queues and the scan pointer, and works out the result
// of every accepted word. Results from the m_* stream are compared in
// order against those predictions. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfq_pkg::*;

  localparam int QDEPTH    = QUEUE_DEPTH_DEF;
  localparam int IBITS     = IDENT_BITS_DEF;
  localparam int WORD_BITS = ((IBITS + 2 + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 550;

  typedef struct {
    status_t           status;
    logic [IBITS-1:0]  ident;
    dir_t              dir;
  } merge_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [WORD_BITS-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_BITS-1:0] m_tdata;
  logic [1:0]           m_tuser;

  // Predicted queue contents and scan pointer.
  logic [IBITS-1:0] ident_store [NUM_QUEUES][QDEPTH];
  int unsigned      head_slot  [NUM_QUEUES];
  int unsigned      fill_level [NUM_QUEUES];
  int unsigned      scan_start;

  merge_result_t pending_results[$];
  int            error_count = 0;
  int            words_sent  = 0;
  bit            sender_gaps_on = 1'b1;

  // Receiver stall pattern.
  int ready_run   = 0;
  bit ready_level = 1'b0;
  int ready_pick;

  round_robin_four_queue_merge #(
    .QUEUE_DEPTH (QDEPTH),
    .IDENT_BITS  (IBITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("round_robin_four_queue_merge test failed");
    $finish;
  end

  function automatic int unsigned queued_total();
    int unsigned sum;
    sum = 0;
    for (int q = 0; q < NUM_QUEUES; q++) sum += fill_level[q];
    return sum;
  endfunction

  function automatic merge_result_t predict_merge(kind_t kind, dir_t dir,
                                                  logic [IBITS-1:0] ident);
    merge_result_t res;
    int unsigned   q;
    int unsigned   slot;
    bit            found;
    res.status = ST_PUSHED;
    res.ident  = '0;
    res.dir    = DIR_WEST;
    found      = 1'b0;
    q          = 0;
    if (kind == KIND_PUSH) begin
      if (fill_level[dir] >= QDEPTH) begin
        res.status = ST_DROPPED;
      end else begin
        slot = (head_slot[dir] + fill_level[dir]) % QDEPTH;
        ident_store[dir][slot] = ident;
        fill_level[dir]++;
      end
    end else begin
      for (int k = 0; k < NUM_QUEUES && !found; k++) begin
        q = (scan_start + k) % NUM_QUEUES;
        if (fill_level[q] != 0) found = 1'b1;
      end
      if (!found) begin
        res.status = ST_EMPTY;
      end else begin
        res.status   = ST_POPPED;
        res.ident    = ident_store[q][head_slot[q]];
        res.dir      = dir_t'(q);
        head_slot[q] = (head_slot[q] + 1) % QDEPTH;
        fill_level[q]--;
        scan_start   = (q + 1) % NUM_QUEUES;
        // An emptied store sends the next scan back to west.
        if (queued_total() == 0) scan_start = DIR_WEST;
      end
    end
    return res;
  endfunction

  function automatic logic [IBITS-1:0] rand_ident();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[IBITS-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_gaps_on || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_word(kind_t kind, dir_t dir, logic [IBITS-1:0] ident);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(WORD_BITS - IBITS - 2){1'b0}}, ident, dir};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_merge(kind, dir, ident));
    words_sent++;
  endtask

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word status %0d ident %h dir %0d", $time,
                 m_tuser, m_tdata[IBITS-1:0], m_tdata[IBITS+1:IBITS]);
        error_count++;
      end else begin
        if (m_tuser !== pending_results[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_results[0].status, m_tuser);
          error_count++;
        end
        if (m_tdata[IBITS-1:0] !== pending_results[0].ident) begin
          $display("%0t: out_ident expected %h actual %h", $time,
                   pending_results[0].ident, m_tdata[IBITS-1:0]);
          error_count++;
        end
        if (m_tdata[IBITS+1:IBITS] !== pending_results[0].dir) begin
          $display("%0t: out_direction expected %0d actual %0d", $time,
                   pending_results[0].dir, m_tdata[IBITS+1:IBITS]);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
    if (ready_run == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 45) begin
        ready_level = 1'b1;
        ready_run   = $urandom_range(1, 12);
      end else if (ready_pick < 85) begin
        ready_level = 1'b0;
        ready_run   = $urandom_range(1, 3);
      end else if (ready_pick < 95) begin
        ready_level = 1'b0;
        ready_run   = $urandom_range(10, 40);
      end else begin
        ready_level = 1'b1;
        ready_run   = $urandom_range(60, 200);
      end
    end
    ready_run--;
    m_tready <= ready_level;
  end

  task automatic test_empty_pop();
    send_word(KIND_POP, DIR_WEST, '0);
    // Direction and identifier carry no meaning on a pop.
    send_word(KIND_POP, DIR_EAST, '1);
  endtask

  task automatic test_round_robin_order();
    send_word(KIND_PUSH, DIR_WEST,  '0);
    send_word(KIND_PUSH, DIR_NORTH, '1);
    send_word(KIND_PUSH, DIR_SOUTH, {(IBITS / 2){2'b01}});
    send_word(KIND_PUSH, DIR_EAST,  {(IBITS / 2){2'b10}});
    send_word(KIND_POP,  DIR_WEST,  '0);
    // A push in the middle of a drain is served after the scan wraps.
    send_word(KIND_PUSH, DIR_WEST,  rand_ident());
    repeat (4) send_word(KIND_POP, DIR_NORTH, rand_ident());
    send_word(KIND_POP,  DIR_SOUTH, '0);
  endtask

  task automatic test_scan_restart();
    send_word(KIND_PUSH, DIR_NORTH, rand_ident());
    send_word(KIND_POP,  DIR_WEST,  '0);
    send_word(KIND_PUSH, DIR_EAST,  rand_ident());
    send_word(KIND_PUSH, DIR_WEST,  rand_ident());
    send_word(KIND_POP,  DIR_WEST,  '0);
    send_word(KIND_POP,  DIR_WEST,  '0);
  endtask

  task automatic test_random_traffic();
    int   start_count;
    int   seq_pick;
    int   run_len;
    int   push_pct;
    dir_t fill_dir;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      seq_pick       = $urandom_range(0, 99);
      sender_gaps_on = ($urandom_range(0, 4) != 0);
      if (seq_pick < 45) begin
        run_len  = $urandom_range(10, 40);
        push_pct = $urandom_range(30, 75);
        repeat (run_len) begin
          if ($urandom_range(0, 99) < push_pct)
            send_word(KIND_PUSH, dir_t'($urandom_range(0, 3)), rand_ident());
          else
            send_word(KIND_POP, dir_t'($urandom_range(0, 3)), rand_ident());
        end
      end else if (seq_pick < 70) begin
        // Fill one queue up to and sometimes past its capacity.
        fill_dir = dir_t'($urandom_range(0, 3));
        run_len  = QDEPTH - fill_level[fill_dir] + $urandom_range(0, 3);
        repeat (run_len) send_word(KIND_PUSH, fill_dir, rand_ident());
      end else if (seq_pick < 90) begin
        while (queued_total() != 0)
          send_word(KIND_POP, dir_t'($urandom_range(0, 3)), rand_ident());
        send_word(KIND_POP, dir_t'($urandom_range(0, 3)), rand_ident());
      end else begin
        run_len = $urandom_range(1, 8);
        repeat (run_len)
          send_word(kind_t'($urandom_range(0, 1)), dir_t'($urandom_range(0, 3)),
                    rand_ident());
      end
    end
  endtask

  initial begin
    int drain_wait;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      head_slot[q]  = 0;
      fill_level[q] = 0;
    end
    scan_start = DIR_WEST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_pop();
    test_round_robin_order();
    test_scan_restart();
    test_random_traffic();
    s_tvalid <= 1'b0;

    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_results.size());
      error_count++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("round_robin_four_queue_merge test passed");
    end else begin
      $display("round_robin_four_queue_merge test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/rrfq_pkg.sv
design/rrfq_front.sv
design/rrfq_back.sv
design/round_robin_four_queue_merge.sv
design/rrfq_checker.sv
verif/tb_top.sv
